### src/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg: shared definitions for the repeated matrix squaring block
// Widths, register indexes, reset values and the control types passed
// between the sequencer and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  // Element width: two's complement, all arithmetic wraps here
  localparam int unsigned DataW    = 32;
  // Configuration register widths
  localparam int unsigned DimCfgW  = 4;
  localparam int unsigned CountW   = 8;
  // Load counter and element total (total reaches 64)
  localparam int unsigned LoadCntW = 7;
  localparam int unsigned TotalW   = 7;
  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam int unsigned DefMaxDim = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMatrixSize    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSquaringCount = 2'd1;

  // Reset values
  localparam logic [DimCfgW-1:0] ResetMatrixSize    = 4'd8;
  localparam logic [CountW-1:0]  ResetSquaringCount = 8'd1;

  // Control stages inside the multiply-accumulate unit after the read issue
  localparam int unsigned MacLatency = 2;

  typedef enum logic [4:0] {
    StLoad  = 5'b00001,
    StMac   = 5'b00010,
    StDrain = 5'b00100,
    StCopy  = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // Control that travels with one operand pair
  typedef struct packed {
    logic valid;
    logic first;  // first term of a dot product
    logic last;   // last term of a dot product
  } mac_ctl_t;

endpackage

`default_nettype wire

### src/repeated_matrix_squaring.sv
// ----------------------------------------------------------------------------
// repeated_matrix_squaring: raise a square integer matrix to 2**k
// Loads an n x n signed matrix row-major, squares it the configured number
// of times with one shared multiply-accumulate unit, then streams it out.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, element_value_i   | request in
//  out     | out_valid_o, out_ready_i, result_value_o, | request out
//          | is_last_o                                 |
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | request in
//          |   cfg_data_i                              |
//
//  Sequence: loading takes element requests back to back. After the last
//  of a matrix, each squaring issues every multiply-accumulate term (one term
//  per cycle through the shared unit), drains the unit and copies the
//  product store back into the matrix store. Output then starts and
//  streams the elements.
//  Reset: control state clears at once, no clearing pass over the stores.
//  Stalls: in_ready_o stays low from the matrix-completing request until
//  the last result is taken; out_ready_i low holds the current result.
// ----------------------------------------------------------------------------
`default_nettype none

module repeated_matrix_squaring #(
  parameter int unsigned MAX_DIM = rms_pkg::DefMaxDim
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // element input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rms_pkg::DataW-1:0]    element_value_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rms_pkg::DataW-1:0]    result_value_o,
  output logic                                is_last_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [rms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [rms_pkg::CfgDataW-1:0] cfg_data_i
);
  import rms_pkg::*;

  localparam int unsigned AddrW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned DimW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // Configuration registers
  logic [DimCfgW-1:0]  size_q, size_d;
  logic [CountW-1:0]   count_q, count_d;

  // Sequencer state
  state_e              state_q, state_d;
  logic [LoadCntW-1:0] load_cnt_q, load_cnt_d;
  logic [DimW-1:0]     row_q, row_d, col_q, col_d, k_q, k_d;
  logic [AddrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [1:0]          drain_q, drain_d;
  logic [TotalW-1:0]   copy_idx_q, copy_idx_d;
  logic                copy_vld_q, copy_vld_d;
  logic [AddrW-1:0]    copy_addr_q;
  logic [CountW-1:0]   iter_q, iter_d;
  logic [TotalW-1:0]   out_idx_q, out_idx_d;
  logic                out_vld_q, out_vld_d;

  // Derived sizes
  logic [DimCfgW-1:0]  dim;
  logic [DimCfgW-1:0]  dim_m1;
  logic [TotalW-1:0]   total;
  logic [LoadCntW-1:0] load_next;
  logic                load_done;
  logic                k_end, col_end, row_end;
  logic                in_acc, out_acc, out_end;

  // Store ports
  logic                mat_we;
  logic [AddrW-1:0]    mat_wa;
  logic [DataW-1:0]    mat_wd;
  logic [AddrW-1:0]    mat_ra [2];
  logic [DataW-1:0]    mat_rd [2];
  logic [AddrW-1:0]    prod_ra [1];
  logic [DataW-1:0]    prod_rd [1];
  logic [AddrW-1:0]    a_addr, b_addr;

  // MAC unit
  mac_ctl_t            issue;
  logic                sum_valid;
  logic [DataW-1:0]    sum;

  // Clamp the size into 1..MAX_DIM
  always_comb begin
    if (size_q == '0) begin
      dim = DimCfgW'(1);
    end else if (size_q > DimCfgW'(MAX_DIM)) begin
      dim = DimCfgW'(MAX_DIM);
    end else begin
      dim = size_q;
    end
  end

  assign dim_m1    = dim - DimCfgW'(1);
  assign total     = TotalW'(dim) * TotalW'(dim);
  assign load_next = load_cnt_q + LoadCntW'(1);
  assign load_done = (TotalW'(load_next) >= total);

  assign k_end   = (DimCfgW'(k_q) == dim_m1);
  assign col_end = (DimCfgW'(col_q) == dim_m1);
  assign row_end = (DimCfgW'(row_q) == dim_m1);

  // Operand addresses: A[row][k] and A[k][col]
  assign a_addr = AddrW'(row_q) * AddrW'(dim) + AddrW'(k_q);
  assign b_addr = AddrW'(k_q) * AddrW'(dim) + AddrW'(col_q);

  assign in_ready_o  = (state_q == StLoad);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_acc     = out_vld_q & out_ready_i;
  assign out_end     = (out_idx_q == total - TotalW'(1));
  assign is_last_o   = out_vld_q & out_end;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    wr_ptr_d   = wr_ptr_q;
    drain_d    = drain_q;
    copy_idx_d = copy_idx_q;
    copy_vld_d = 1'b0;
    iter_d     = iter_q;
    out_idx_d  = out_idx_q;
    out_vld_d  = out_vld_q;
    size_d     = size_q;
    count_d    = count_q;
    mat_we     = 1'b0;
    mat_wa     = copy_addr_q;
    mat_wd     = prod_rd[0];
    issue      = '0;

    // Advance the product write pointer on each finished dot product
    if (sum_valid) begin
      wr_ptr_d = wr_ptr_q + AddrW'(1);
    end

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          mat_we = 1'b1;
          mat_wa = load_cnt_q[AddrW-1:0];
          mat_wd = element_value_i;
          if (load_done) begin
            load_cnt_d = '0;
            row_d      = '0;
            col_d      = '0;
            k_d        = '0;
            wr_ptr_d   = '0;
            iter_d     = '0;
            out_idx_d  = '0;
            state_d    = (count_q == '0) ? StOut : StMac;
          end else begin
            load_cnt_d = load_next;
          end
        end
      end

      StMac: begin
        // Issue one term per cycle: k inner, then column, then row
        issue.valid = 1'b1;
        issue.first = (k_q == '0);
        issue.last  = k_end;
        if (!k_end) begin
          k_d = k_q + DimW'(1);
        end else begin
          k_d = '0;
          if (!col_end) begin
            col_d = col_q + DimW'(1);
          end else begin
            col_d = '0;
            if (!row_end) begin
              row_d = row_q + DimW'(1);
            end else begin
              row_d   = '0;
              drain_d = '0;
              state_d = StDrain;
            end
          end
        end
      end

      StDrain: begin
        // Wait for the last sum to land in the product store
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'(MacLatency - 1)) begin
          copy_idx_d = '0;
          state_d    = StCopy;
        end
      end

      StCopy: begin
        if (copy_vld_q) begin
          mat_we = 1'b1;
        end
        if (copy_idx_q != total) begin
          copy_vld_d = 1'b1;
          copy_idx_d = copy_idx_q + TotalW'(1);
        end else begin
          iter_d = iter_q + CountW'(1);
          if ({1'b0, iter_q} + 9'd1 == {1'b0, count_q}) begin
            out_idx_d = '0;
            state_d   = StOut;
          end else begin
            row_d    = '0;
            col_d    = '0;
            k_d      = '0;
            wr_ptr_d = '0;
            state_d  = StMac;
          end
        end
      end

      StOut: begin
        if (!out_vld_q) begin
          out_vld_d = 1'b1;
        end else if (out_ready_i) begin
          if (out_end) begin
            out_vld_d = 1'b0;
            state_d   = StLoad;
          end else begin
            out_idx_d = out_idx_q + TotalW'(1);
          end
        end
      end

      default: begin
        state_d = StLoad;
      end
    endcase

    // Configuration writes; out-of-range indexes drop
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMatrixSize:    size_d  = cfg_data_i[DimCfgW-1:0];
        RegSquaringCount: count_d = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Read addresses: port 0 serves the A operand and the output stream
  always_comb begin
    mat_ra[0]  = (state_q == StOut) ? out_idx_d[AddrW-1:0] : a_addr;
    mat_ra[1]  = b_addr;
    prod_ra[0] = copy_idx_q[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
      wr_ptr_q   <= '0;
      drain_q    <= '0;
      copy_idx_q <= '0;
      copy_vld_q <= 1'b0;
      iter_q     <= '0;
      out_idx_q  <= '0;
      out_vld_q  <= 1'b0;
      size_q     <= ResetMatrixSize;
      count_q    <= ResetSquaringCount;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      k_q        <= k_d;
      wr_ptr_q   <= wr_ptr_d;
      drain_q    <= drain_d;
      copy_idx_q <= copy_idx_d;
      copy_vld_q <= copy_vld_d;
      iter_q     <= iter_d;
      out_idx_q  <= out_idx_d;
      out_vld_q  <= out_vld_d;
      size_q     <= size_d;
      count_q    <= count_d;
    end
  end

  // Hold the copy address alongside the registered product read
  always_ff @(posedge clk_i) begin
    copy_addr_q <= copy_idx_q[AddrW-1:0];
  end

  assign result_value_o = mat_rd[0];

  rms_mem #(
    .DataW  (DataW),
    .AddrW  (AddrW),
    .Depth  (Depth),
    .RdPorts(2)
  ) u_matrix_store (
    .clk_i    (clk_i),
    .wr_en_i  (mat_we),
    .wr_addr_i(mat_wa),
    .wr_data_i(mat_wd),
    .rd_addr_i(mat_ra),
    .rd_data_o(mat_rd)
  );

  rms_mem #(
    .DataW  (DataW),
    .AddrW  (AddrW),
    .Depth  (Depth),
    .RdPorts(1)
  ) u_product_store (
    .clk_i    (clk_i),
    .wr_en_i  (sum_valid),
    .wr_addr_i(wr_ptr_q),
    .wr_data_i(sum),
    .rd_addr_i(prod_ra),
    .rd_data_o(prod_rd)
  );

  rms_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .op_a_i     (mat_rd[0]),
    .op_b_i     (mat_rd[1]),
    .sum_valid_o(sum_valid),
    .sum_o      (sum)
  );

endmodule

`default_nettype wire

### src/rms_mem.sv
// ----------------------------------------------------------------------------
// rms_mem: element store
// One write port and a configurable number of read ports, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_mem #(
  parameter int unsigned DataW   = 32,
  parameter int unsigned AddrW   = 6,
  parameter int unsigned Depth   = 64,
  parameter int unsigned RdPorts = 2
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i [RdPorts],
  output logic [DataW-1:0] rd_data_o [RdPorts]
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  for (genvar p = 0; p < RdPorts; p++) begin : g_rd
    always_ff @(posedge clk_i) begin
      rd_data_o[p] <= mem_q[rd_addr_i[p]];
    end
  end

endmodule

`default_nettype wire

### src/rms_mac.sv
// ----------------------------------------------------------------------------
// rms_mac: shared multiply-accumulate unit
// Registers the product of two elements, then folds it into the running
// dot product. Flags a finished sum on the last term.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rms_pkg::mac_ctl_t         issue_i,   // cycle of the read issue
  input  logic [rms_pkg::DataW-1:0] op_a_i,    // in the cycle after issue
  input  logic [rms_pkg::DataW-1:0] op_b_i,
  output logic                      sum_valid_o,
  output logic [rms_pkg::DataW-1:0] sum_o
);
  import rms_pkg::*;

  mac_ctl_t         ctl1_q, ctl2_q;
  logic [DataW-1:0] product_q;
  logic [DataW-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= issue_i;
      ctl2_q <= ctl1_q;
    end
  end

  // Low 32 bits of the product, wrapped
  always_ff @(posedge clk_i) begin
    product_q <= op_a_i * op_b_i;
  end

  always_comb begin
    acc_d = ctl2_q.first ? product_q : acc_q + product_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign sum_valid_o = ctl2_q.valid & ctl2_q.last;
  assign sum_o       = acc_d;

endmodule

`default_nettype wire

### src/rms_checker.sv
// ----------------------------------------------------------------------------
// rms_checker: port-level checks for repeated_matrix_squaring
// Watches the handshakes and the result framing over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic signed [rms_pkg::DataW-1:0]    element_value_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [rms_pkg::DataW-1:0]    result_value_o,
  input wire logic                                is_last_o,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_o,
  input wire logic        [rms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input wire logic        [rms_pkg::CfgDataW-1:0] cfg_data_i
);

  // No new element is taken while results are pending
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("element request accepted while results pending");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(result_value_o) && $stable(is_last_o))
    else $error("stalled result changed");

  // The last result closes the frame and reopens the input
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && is_last_o |=> !out_valid_o && in_ready_o)
    else $error("frame not closed after last result");

  // The last flag only travels with a result
  a_last_framed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last_o |-> out_valid_o)
    else $error("last flag without result");

endmodule

bind repeated_matrix_squaring rms_checker u_rms_checker (.*);

`default_nettype wire
